@@ rtl/core/sql_token_scanner_top_assert.svh @@
// Assertion macros for the SQL token scanner top level.
`ifndef SQL_TOKEN_SCANNER_TOP_ASSERT_SVH
`define SQL_TOKEN_SCANNER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define STS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sql token scanner: check failed");

// Next-cycle implication, disabled during reset.
`define STS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sql token scanner: check failed");

`endif

@@ rtl/core/sts_pkg.sv @@
// Shared types and constants for the SQL token scanner.
`timescale 1ns / 1ps

package sts_pkg;

    localparam int MaxText = 65536;
    localparam int QDepth  = 4;
    localparam int MaxRes  = 3;

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_WORD,
        MODE_STR,
        MODE_LT,
        MODE_GT,
        MODE_BANG,
        MODE_ISWS1,
        MODE_ISW2,
        MODE_ISWS2,
        MODE_ISW3
    } mode_t;

    typedef enum logic [4:0] {
        KIND_END       = 5'd0,
        KIND_WORD      = 5'd1,
        KIND_STRING    = 5'd2,
        KIND_EQ        = 5'd3,
        KIND_NE        = 5'd4,
        KIND_LT        = 5'd5,
        KIND_LE        = 5'd6,
        KIND_GT        = 5'd7,
        KIND_GE        = 5'd8,
        KIND_LPAREN    = 5'd9,
        KIND_RPAREN    = 5'd10,
        KIND_SEMI      = 5'd11,
        KIND_COMMA     = 5'd12,
        KIND_UNKNOWN   = 5'd13,
        KIND_ISNULL    = 5'd14,
        KIND_ISNOTNULL = 5'd15,
        KIND_ERROR     = 5'd16
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] start;
        logic [15:0] len;
    } token_t;

    // All tokens caused by one character, in order.
    typedef struct packed {
        token_t [MaxRes-1:0] tok;
        logic   [1:0]        cnt;
    } bundle_t;

    typedef struct packed {
        logic    valid;
        bundle_t data;
    } push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

@@ rtl/core/sts_front.sv @@
// Front end: accepts characters, runs the scanner state, builds token bundles.
`timescale 1ns / 1ps

module sts_front #(
    parameter int MAX_TEXT = sts_pkg::MaxText
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        char_code,
    input  logic              final_char,
    input  sts_pkg::q_stat_t  q_stat,
    output sts_pkg::push_t    q_push
);

    localparam int PW = $clog2(MAX_TEXT + 1);
    localparam logic [PW-1:0] MaxPos = PW'(MAX_TEXT);

    sts_pkg::mode_t         mode_reg, mode_next;
    logic [PW-1:0]          pos_reg, pos_next;
    logic [PW-1:0]          ts_reg, ts_next;
    logic [PW-1:0]          wc_reg, wc_next;
    logic [3:0][7:0]        wm_reg, wm_next;
    logic [PW-1:0]          iphs_reg, iphs_next;
    logic                   failed_reg, failed_next;

    logic                   accept;
    logic                   ends;
    logic                   is_ws;
    logic                   is_an;
    logic                   is_wb;
    logic [PW-1:0]          wc_add;
    logic [3:0][7:0]        wm_add;
    sts_pkg::token_t [3:0]  toks;
    logic [2:0]             n_tok;
    logic                   go_ws;
    logic                   go_fresh;
    logic                   end_fail;

    function automatic logic [15:0] sat16(input logic [PW-1:0] v);
        if ((v >> 16) != '0) begin
            return 16'hFFFF;
        end
        return 16'(v);
    endfunction

    function automatic sts_pkg::token_t mk_tok(input sts_pkg::kind_t k,
                                               input logic [PW-1:0] s,
                                               input logic [PW-1:0] l);
        sts_pkg::token_t t;
        t.kind  = k;
        t.start = 16'(s);
        t.len   = sat16(l);
        return t;
    endfunction

    function automatic logic word_is_is(input logic [PW-1:0] wc, input logic [3:0][7:0] wm);
        return (wc == PW'(2)) && (wm[0] == "I") && (wm[1] == "S");
    endfunction

    function automatic logic word_is_not(input logic [PW-1:0] wc, input logic [3:0][7:0] wm);
        return (wc == PW'(3)) && (wm[0] == "N") && (wm[1] == "O") && (wm[2] == "T");
    endfunction

    function automatic logic word_is_null(input logic [PW-1:0] wc, input logic [3:0][7:0] wm);
        return (wc == PW'(4)) && (wm[0] == "N") && (wm[1] == "U") && (wm[2] == "L")
            && (wm[3] == "L");
    endfunction

    function automatic sts_pkg::kind_t symbol_kind(input logic [7:0] c);
        case (c)
            "=":     return sts_pkg::KIND_EQ;
            "(":     return sts_pkg::KIND_LPAREN;
            ")":     return sts_pkg::KIND_RPAREN;
            ";":     return sts_pkg::KIND_SEMI;
            ",":     return sts_pkg::KIND_COMMA;
            default: return sts_pkg::KIND_UNKNOWN;
        endcase
    endfunction

    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;
    assign ends     = (char_code == 8'd0) || final_char;

    assign is_ws = (char_code == 8'd32) || (char_code inside {[8'd9:8'd13]});
    assign is_an = (char_code inside {["0":"9"], ["A":"Z"], ["a":"z"]}) || (char_code == "_");
    assign is_wb = is_an || (char_code == ".");

    assign wc_add = (wc_reg < MaxPos) ? wc_reg + PW'(1) : wc_reg;

    always_comb
    begin
        wm_add = wm_reg;
        if (wc_reg < PW'(4))
        begin
            wm_add[wc_reg[1:0]] = char_code;
        end
    end

    always_comb
    begin
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        ts_next     = ts_reg;
        wc_next     = wc_reg;
        wm_next     = wm_reg;
        iphs_next   = iphs_reg;
        failed_next = failed_reg;
        toks        = '0;
        n_tok       = '0;
        go_ws       = 1'b0;
        go_fresh    = 1'b0;
        end_fail    = 1'b0;

        if (accept)
        begin
            if (!failed_reg && (char_code != 8'd0))
            begin
                if (pos_reg >= MaxPos)
                begin
                    toks[n_tok[1:0]] = mk_tok(sts_pkg::KIND_ERROR, pos_reg, '0);
                    n_tok            = n_tok + 3'd1;
                    failed_next      = 1'b1;
                    mode_next        = sts_pkg::MODE_IDLE;
                end
                else
                begin
                    pos_next = pos_reg + PW'(1);
                    case (mode_reg)
                        sts_pkg::MODE_WORD:
                        begin
                            if (is_wb)
                            begin
                                wc_next = wc_add;
                                wm_next = wm_add;
                            end
                            else if (word_is_is(wc_reg, wm_reg))
                            begin
                                iphs_next = ts_reg;
                                mode_next = sts_pkg::MODE_ISWS1;
                                go_ws     = 1'b1;
                            end
                            else
                            begin
                                toks[n_tok[1:0]] = mk_tok(sts_pkg::KIND_WORD, ts_reg, wc_reg);
                                n_tok            = n_tok + 3'd1;
                                go_fresh         = 1'b1;
                            end
                        end
                        sts_pkg::MODE_ISWS1, sts_pkg::MODE_ISWS2:
                        begin
                            if (!is_ws)
                            begin
                                if (is_wb)
                                begin
                                    wc_next    = PW'(1);
                                    wm_next[0] = char_code;
                                    mode_next  = (mode_reg == sts_pkg::MODE_ISWS1) ?
                                                 sts_pkg::MODE_ISW2 : sts_pkg::MODE_ISW3;
                                end
                                else
                                begin
                                    toks[n_tok[1:0]] = mk_tok(sts_pkg::KIND_ERROR, iphs_reg, '0);
                                    n_tok            = n_tok + 3'd1;
                                    failed_next      = 1'b1;
                                    mode_next        = sts_pkg::MODE_IDLE;
                                end
                            end
                        end
                        sts_pkg::MODE_ISW2, sts_pkg::MODE_ISW3:
                        begin
                            if (is_wb)
                            begin
                                wc_next = wc_add;
                                wm_next = wm_add;
                            end
                            else if (word_is_null(wc_reg, wm_reg))
                            begin
                                toks[n_tok[1:0]] = (mode_reg == sts_pkg::MODE_ISW2) ?
                                    mk_tok(sts_pkg::KIND_ISNULL, iphs_reg, PW'(7)) :
                                    mk_tok(sts_pkg::KIND_ISNOTNULL, iphs_reg, PW'(11));
                                n_tok    = n_tok + 3'd1;
                                go_fresh = 1'b1;
                            end
                            else if ((mode_reg == sts_pkg::MODE_ISW2)
                                     && word_is_not(wc_reg, wm_reg))
                            begin
                                mode_next = sts_pkg::MODE_ISWS2;
                                go_ws     = 1'b1;
                            end
                            else
                            begin
                                toks[n_tok[1:0]] = mk_tok(sts_pkg::KIND_ERROR, iphs_reg, '0);
                                n_tok            = n_tok + 3'd1;
                                failed_next      = 1'b1;
                                mode_next        = sts_pkg::MODE_IDLE;
                            end
                        end
                        sts_pkg::MODE_STR:
                        begin
                            if (char_code == "'")
                            begin
                                toks[n_tok[1:0]] = mk_tok(sts_pkg::KIND_STRING, ts_reg, wc_reg);
                                n_tok            = n_tok + 3'd1;
                                mode_next        = sts_pkg::MODE_IDLE;
                            end
                            else
                            begin
                                wc_next = wc_add;
                            end
                        end
                        sts_pkg::MODE_LT, sts_pkg::MODE_GT, sts_pkg::MODE_BANG:
                        begin
                            mode_next = sts_pkg::MODE_IDLE;
                            if (char_code == "=")
                            begin
                                toks[n_tok[1:0]] = mk_tok(
                                    (mode_reg == sts_pkg::MODE_LT) ? sts_pkg::KIND_LE :
                                    (mode_reg == sts_pkg::MODE_GT) ? sts_pkg::KIND_GE :
                                    sts_pkg::KIND_NE, ts_reg, PW'(2));
                                n_tok = n_tok + 3'd1;
                            end
                            else
                            begin
                                toks[n_tok[1:0]] = mk_tok(
                                    (mode_reg == sts_pkg::MODE_LT) ? sts_pkg::KIND_LT :
                                    (mode_reg == sts_pkg::MODE_GT) ? sts_pkg::KIND_GT :
                                    sts_pkg::KIND_UNKNOWN, ts_reg, PW'(1));
                                n_tok    = n_tok + 3'd1;
                                go_fresh = 1'b1;
                            end
                        end
                        default:
                        begin
                            go_fresh = 1'b1;
                        end
                    endcase

                    // IS or IS NOT just closed on a byte that is not whitespace, which is an error
                    if (go_ws && !is_ws)
                    begin
                        toks[n_tok[1:0]] = mk_tok(sts_pkg::KIND_ERROR, iphs_next, '0);
                        n_tok            = n_tok + 3'd1;
                        failed_next      = 1'b1;
                        mode_next        = sts_pkg::MODE_IDLE;
                    end

                    // rescan the byte from the idle state
                    if (go_fresh)
                    begin
                        mode_next = sts_pkg::MODE_IDLE;
                        if (!is_ws)
                        begin
                            ts_next = pos_reg;
                            if (is_an)
                            begin
                                wc_next    = PW'(1);
                                wm_next[0] = char_code;
                                mode_next  = sts_pkg::MODE_WORD;
                            end
                            else if (char_code == "'")
                            begin
                                ts_next   = pos_reg + PW'(1);
                                wc_next   = '0;
                                mode_next = sts_pkg::MODE_STR;
                            end
                            else if (char_code == "<")
                            begin
                                mode_next = sts_pkg::MODE_LT;
                            end
                            else if (char_code == ">")
                            begin
                                mode_next = sts_pkg::MODE_GT;
                            end
                            else if (char_code == "!")
                            begin
                                mode_next = sts_pkg::MODE_BANG;
                            end
                            else
                            begin
                                toks[n_tok[1:0]] = mk_tok(symbol_kind(char_code), pos_reg, PW'(1));
                                n_tok            = n_tok + 3'd1;
                            end
                        end
                    end
                end
            end

            if (ends)
            begin
                if (!failed_next)
                begin
                    // flush whatever token is still open
                    case (mode_next)
                        sts_pkg::MODE_WORD:
                        begin
                            if (word_is_is(wc_next, wm_next))
                            begin
                                toks[n_tok[1:0]] = mk_tok(sts_pkg::KIND_ERROR, ts_next, '0);
                                end_fail         = 1'b1;
                            end
                            else
                            begin
                                toks[n_tok[1:0]] = mk_tok(sts_pkg::KIND_WORD, ts_next, wc_next);
                            end
                            n_tok = n_tok + 3'd1;
                        end
                        sts_pkg::MODE_ISWS1, sts_pkg::MODE_ISWS2:
                        begin
                            toks[n_tok[1:0]] = mk_tok(sts_pkg::KIND_ERROR, iphs_next, '0);
                            n_tok            = n_tok + 3'd1;
                            end_fail         = 1'b1;
                        end
                        sts_pkg::MODE_ISW2, sts_pkg::MODE_ISW3:
                        begin
                            if (word_is_null(wc_next, wm_next))
                            begin
                                toks[n_tok[1:0]] = (mode_next == sts_pkg::MODE_ISW2) ?
                                    mk_tok(sts_pkg::KIND_ISNULL, iphs_next, PW'(7)) :
                                    mk_tok(sts_pkg::KIND_ISNOTNULL, iphs_next, PW'(11));
                            end
                            else
                            begin
                                toks[n_tok[1:0]] = mk_tok(sts_pkg::KIND_ERROR, iphs_next, '0);
                                end_fail         = 1'b1;
                            end
                            n_tok = n_tok + 3'd1;
                        end
                        sts_pkg::MODE_STR:
                        begin
                            toks[n_tok[1:0]] = mk_tok(sts_pkg::KIND_ERROR,
                                                      ts_next - PW'(1), '0);
                            n_tok            = n_tok + 3'd1;
                            end_fail         = 1'b1;
                        end
                        sts_pkg::MODE_LT:
                        begin
                            toks[n_tok[1:0]] = mk_tok(sts_pkg::KIND_LT, ts_next, PW'(1));
                            n_tok            = n_tok + 3'd1;
                        end
                        sts_pkg::MODE_GT:
                        begin
                            toks[n_tok[1:0]] = mk_tok(sts_pkg::KIND_GT, ts_next, PW'(1));
                            n_tok            = n_tok + 3'd1;
                        end
                        sts_pkg::MODE_BANG:
                        begin
                            toks[n_tok[1:0]] = mk_tok(sts_pkg::KIND_UNKNOWN, ts_next, PW'(1));
                            n_tok            = n_tok + 3'd1;
                        end
                        default:
                        begin
                            end_fail = 1'b0;
                        end
                    endcase
                    if (!end_fail && (n_tok < 3'd4))
                    begin
                        toks[n_tok[1:0]] = mk_tok(sts_pkg::KIND_END, pos_next, '0);
                        n_tok            = n_tok + 3'd1;
                    end
                end
                mode_next   = sts_pkg::MODE_IDLE;
                pos_next    = '0;
                ts_next     = '0;
                wc_next     = '0;
                wm_next     = '0;
                iphs_next   = '0;
                failed_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        q_push.valid    = accept && (n_tok != 3'd0);
        q_push.data.tok = toks[sts_pkg::MaxRes-1:0];
        q_push.data.cnt = (n_tok >= 3'd3) ? 2'd3 : n_tok[1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= sts_pkg::MODE_IDLE;
            pos_reg    <= '0;
            ts_reg     <= '0;
            wc_reg     <= '0;
            wm_reg     <= '0;
            iphs_reg   <= '0;
            failed_reg <= 1'b0;
        end
        else
        begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            ts_reg     <= ts_next;
            wc_reg     <= wc_next;
            wm_reg     <= wm_next;
            iphs_reg   <= iphs_next;
            failed_reg <= failed_next;
        end
    end

endmodule

@@ rtl/core/sts_queue.sv @@
// Short FIFO of token bundles between front and back end.
`timescale 1ns / 1ps

module sts_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  sts_pkg::push_t    q_push,
    input  logic              q_pop,
    output sts_pkg::bundle_t  q_head,
    output sts_pkg::q_stat_t  q_stat
);

    localparam int AW = $clog2(sts_pkg::QDepth);
    localparam int CW = $clog2(sts_pkg::QDepth + 1);

    sts_pkg::bundle_t mem_reg [sts_pkg::QDepth];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign do_push = q_push.valid && (count_reg != CW'(sts_pkg::QDepth));
    assign do_pop  = q_pop && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(sts_pkg::QDepth - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(sts_pkg::QDepth - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        count_next = count_reg + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= q_push.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign q_head       = mem_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == CW'(sts_pkg::QDepth));
    assign q_stat.empty = (count_reg == '0);

endmodule

@@ rtl/core/sts_back.sv @@
// Back end: unpacks token bundles into single output transactions.
`timescale 1ns / 1ps

module sts_back (
    input  logic              clk,
    input  logic              rst_n,
    input  sts_pkg::bundle_t  q_head,
    input  sts_pkg::q_stat_t  q_stat,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [4:0]        kind,
    output logic [15:0]       start_offset,
    output logic [15:0]       token_length,
    output logic              run_last
);

    logic             out_valid_reg, out_valid_next;
    sts_pkg::token_t  tok_reg, tok_next;
    logic             last_reg, last_next;
    logic [1:0]       idx_reg, idx_next;
    logic             load;
    logic             at_last;

    assign load    = !q_stat.empty && (!out_valid_reg || out_ready);
    assign at_last = (idx_reg == 2'(q_head.cnt - 2'd1));
    assign q_pop   = load && at_last;

    always_comb
    begin
        tok_next       = tok_reg;
        last_next      = last_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (load)
        begin
            tok_next       = q_head.tok[idx_reg];
            last_next      = at_last;
            idx_next       = at_last ? 2'd0 : idx_reg + 2'd1;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg  <= tok_next;
        last_reg <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = tok_reg.kind;
    assign start_offset = tok_reg.start;
    assign token_length = tok_reg.len;
    assign run_last     = last_reg;

endmodule

@@ rtl/core/sql_token_scanner_top.sv @@
// SQL token scanner: one character in per cycle while the bundle queue is not full, tokens
// out one per cycle while out_ready is high. A character's first token passes through the
// bundle queue and then the output register; a character that yields several tokens sends
// them one at a time, and the four-entry bundle queue absorbs those bursts.
// Reset: asynchronous, clears scanner state, queue pointers and output valid at once.
`timescale 1ns / 1ps

`include "sql_token_scanner_top_assert.svh"

module sql_token_scanner_top #(
    parameter int MAX_TEXT = sts_pkg::MaxText
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_code,
    input  logic        final_char,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [4:0]  kind,
    output logic [15:0] start_offset,
    output logic [15:0] token_length,
    output logic        run_last
);

    sts_pkg::push_t    q_push;
    sts_pkg::q_stat_t  q_stat;
    sts_pkg::bundle_t  q_head;
    logic              q_pop;

    sts_front #(
        .MAX_TEXT (MAX_TEXT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .char_code  (char_code),
        .final_char (final_char),
        .q_stat     (q_stat),
        .q_push     (q_push)
    );

    sts_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_push (q_push),
        .q_pop  (q_pop),
        .q_head (q_head),
        .q_stat (q_stat)
    );

    sts_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_head       (q_head),
        .q_stat       (q_stat),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .start_offset (start_offset),
        .token_length (token_length),
        .run_last     (run_last)
    );

    // end of text always closes a run and carries no length
    `STS_ASSERT_IMP(a_end_shape, out_valid && (kind == sts_pkg::KIND_END), run_last && (token_length == 16'd0))
    // an error stops the text, so nothing follows it in the same run
    `STS_ASSERT_IMP(a_error_shape, out_valid && (kind == sts_pkg::KIND_ERROR), run_last && (token_length == 16'd0))
    `STS_ASSERT_IMP(a_kind_range, out_valid, kind <= sts_pkg::KIND_ERROR)
    // tokens of one character come out without gaps
    `STS_ASSERT_NXT(a_run_cont, out_valid && out_ready && !run_last, out_valid)

endmodule

@@ tb/tb_sql_token_scanner_top.sv @@
// Self-checking testbench for the SQL token scanner: directed table, stall phase, random queries.
`timescale 1ns / 1ps

module tb_sql_token_scanner_top;

    localparam int CycleLimit = 1000000;
    localparam int RandItems  = 110;
    localparam int CalmTail   = 40;
    localparam int LongHold   = 300;
    localparam int HoldPairs  = 20;
    localparam int DrainPad   = 4;
    localparam int EndPad     = 10;
    localparam int DirRows    = 27;

    localparam logic [7:0] ChNul   = 8'h00;
    localparam logic [7:0] ChQuote = 8'h27;
    localparam logic [7:0] ChSpace = 8'h20;
    localparam logic [7:0] ChEq    = "=";
    localparam logic [7:0] ChLt    = "<";
    localparam logic [7:0] ChGt    = ">";
    localparam logic [7:0] ChBang  = "!";
    localparam logic [7:0] ChUnder = "_";
    localparam logic [7:0] ChDot   = ".";
    localparam string      Syms    = "=()<>;,!";

    typedef struct packed {
        sts_pkg::token_t tok;
        logic            last;
    } tok_exp_t;

    typedef struct packed {
        logic [7:0]     ch;
        logic           fin;
        logic           typed;
        sts_pkg::kind_t k;
        logic [15:0]    st;
        logic [15:0]    ln;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  char_code;
    logic        final_char;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [4:0]  kind;
    logic [15:0] start_offset;
    logic [15:0] token_length;
    logic        run_last;

    sql_token_scanner_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .char_code    (char_code),
        .final_char   (final_char),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .start_offset (start_offset),
        .token_length (token_length),
        .run_last     (run_last)
    );

    always #10 clk = ~clk;

    // Scanner shadow state
    sts_pkg::mode_t  sc_mode;
    int unsigned     sc_pos;
    int unsigned     sc_tok_start;
    int unsigned     sc_wlen;
    logic [7:0]      sc_wbuf [4];
    int unsigned     sc_phrase;
    logic            sc_failed;

    sts_pkg::token_t step_toks [$];
    tok_exp_t        expected_tokens [$];

    int          err_count = 0;
    int          tokens_seen = 0;
    int unsigned cycle_cnt = 0;
    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;
    int          hold_asked = 0;
    int          hold_seen = 0;
    int          rx_stall = 0;
    int          rand_sent = 0;
    logic [7:0]  text_buf [$];
    logic        text_fin;
    tok_exp_t    mon_want;

    dir_row_t dir_tab [DirRows] = '{
        '{"(",   1'b0, 1'b1, sts_pkg::KIND_LPAREN,  16'd0, 16'd1},
        '{"<",   1'b0, 1'b0, sts_pkg::KIND_END,     16'd0, 16'd0},
        '{"a",   1'b0, 1'b0, sts_pkg::KIND_END,     16'd0, 16'd0},
        '{"!",   1'b0, 1'b0, sts_pkg::KIND_END,     16'd0, 16'd0},
        '{"=",   1'b0, 1'b0, sts_pkg::KIND_END,     16'd0, 16'd0},
        '{"!",   1'b0, 1'b0, sts_pkg::KIND_END,     16'd0, 16'd0},
        '{">",   1'b0, 1'b0, sts_pkg::KIND_END,     16'd0, 16'd0},
        '{"=",   1'b0, 1'b0, sts_pkg::KIND_END,     16'd0, 16'd0},
        '{8'hFF, 1'b0, 1'b1, sts_pkg::KIND_UNKNOWN, 16'd8, 16'd1},
        '{8'h80, 1'b0, 1'b1, sts_pkg::KIND_UNKNOWN, 16'd9, 16'd1},
        '{"I",   1'b0, 1'b0, sts_pkg::KIND_END,     16'd0, 16'd0},
        '{"S",   1'b0, 1'b0, sts_pkg::KIND_END,     16'd0, 16'd0},
        '{" ",   1'b0, 1'b0, sts_pkg::KIND_END,     16'd0, 16'd0},
        '{"N",   1'b0, 1'b0, sts_pkg::KIND_END,     16'd0, 16'd0},
        '{"U",   1'b0, 1'b0, sts_pkg::KIND_END,     16'd0, 16'd0},
        '{"L",   1'b0, 1'b0, sts_pkg::KIND_END,     16'd0, 16'd0},
        '{"L",   1'b1, 1'b0, sts_pkg::KIND_END,     16'd0, 16'd0},
        '{8'h00, 1'b0, 1'b1, sts_pkg::KIND_END,     16'd0, 16'd0},
        '{"'",   1'b0, 1'b0, sts_pkg::KIND_END,     16'd0, 16'd0},
        '{"q",   1'b1, 1'b1, sts_pkg::KIND_ERROR,   16'd0, 16'd0},
        '{"I",   1'b0, 1'b0, sts_pkg::KIND_END,     16'd0, 16'd0},
        '{"S",   1'b0, 1'b0, sts_pkg::KIND_END,     16'd0, 16'd0},
        '{"=",   1'b0, 1'b1, sts_pkg::KIND_ERROR,   16'd0, 16'd0},
        '{"x",   1'b0, 1'b0, sts_pkg::KIND_END,     16'd0, 16'd0},
        '{8'h00, 1'b0, 1'b0, sts_pkg::KIND_END,     16'd0, 16'd0},
        '{"I",   1'b0, 1'b0, sts_pkg::KIND_END,     16'd0, 16'd0},
        '{"S",   1'b1, 1'b1, sts_pkg::KIND_ERROR,   16'd0, 16'd0}
    };

    // ---------------- scanner prediction ----------------

    function automatic bit is_space(logic [7:0] c);
        return (c == ChSpace) || (c inside {[8'd9:8'd13]});
    endfunction

    function automatic bit is_alnum(logic [7:0] c);
        return c inside {["0":"9"], ["A":"Z"], ["a":"z"]};
    endfunction

    function automatic bit is_wordc(logic [7:0] c);
        return is_alnum(c) || c == ChUnder || c == ChDot;
    endfunction

    function automatic sts_pkg::kind_t symbol_kind(logic [7:0] c);
        case (c)
            "=":     return sts_pkg::KIND_EQ;
            "(":     return sts_pkg::KIND_LPAREN;
            ")":     return sts_pkg::KIND_RPAREN;
            ";":     return sts_pkg::KIND_SEMI;
            ",":     return sts_pkg::KIND_COMMA;
            default: return sts_pkg::KIND_UNKNOWN;
        endcase
    endfunction

    function automatic void clear_scan();
        sc_mode      = sts_pkg::MODE_IDLE;
        sc_pos       = 0;
        sc_tok_start = 0;
        sc_wlen      = 0;
        for (int i = 0; i < 4; i++) sc_wbuf[i] = 8'h00;
        sc_phrase    = 0;
        sc_failed    = 1'b0;
    endfunction

    function automatic void emit_tok(sts_pkg::kind_t k, int unsigned st, int unsigned ln);
        sts_pkg::token_t t;
        if (step_toks.size() >= sts_pkg::MaxRes) return;
        t.kind  = k;
        t.start = st[15:0];
        t.len   = (ln > 65535) ? 16'hFFFF : ln[15:0];
        step_toks.push_back(t);
    endfunction

    function automatic void fail_at(int unsigned st);
        emit_tok(sts_pkg::KIND_ERROR, st, 0);
        sc_failed = 1'b1;
        sc_mode   = sts_pkg::MODE_IDLE;
    endfunction

    function automatic void word_begin(logic [7:0] c);
        sc_wlen    = 1;
        sc_wbuf[0] = c;
    endfunction

    function automatic void word_add(logic [7:0] c);
        if (sc_wlen < 4) sc_wbuf[sc_wlen] = c;
        if (sc_wlen < sts_pkg::MaxText) sc_wlen++;
    endfunction

    function automatic bit word_is(string s);
        if (sc_wlen != s.len()) return 1'b0;
        for (int i = 0; i < s.len(); i++)
            if (sc_wbuf[i] != s[i]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic void scan_byte(logic [7:0] c, int unsigned p);
        bit             again;
        sts_pkg::kind_t pair;
        sts_pkg::kind_t single;
        again = 1'b1;
        while (again) begin
            again = 1'b0;
            case (sc_mode)
                sts_pkg::MODE_WORD:
                begin
                    if (is_wordc(c)) word_add(c);
                    else begin
                        if (word_is("IS"))
                        begin
                            sc_phrase = sc_tok_start;
                            sc_mode   = sts_pkg::MODE_ISWS1;
                        end
                        else
                        begin
                            emit_tok(sts_pkg::KIND_WORD, sc_tok_start, sc_wlen);
                            sc_mode = sts_pkg::MODE_IDLE;
                        end
                        again = 1'b1;
                    end
                end
                sts_pkg::MODE_ISWS1, sts_pkg::MODE_ISWS2:
                begin
                    if (is_space(c)) begin end
                    else if (is_wordc(c))
                    begin
                        word_begin(c);
                        sc_mode = (sc_mode == sts_pkg::MODE_ISWS1) ?
                                  sts_pkg::MODE_ISW2 : sts_pkg::MODE_ISW3;
                    end
                    else fail_at(sc_phrase);
                end
                sts_pkg::MODE_ISW2:
                begin
                    if (is_wordc(c)) word_add(c);
                    else if (word_is("NULL"))
                    begin
                        emit_tok(sts_pkg::KIND_ISNULL, sc_phrase, 7);
                        sc_mode = sts_pkg::MODE_IDLE;
                        again   = 1'b1;
                    end
                    else if (word_is("NOT"))
                    begin
                        sc_mode = sts_pkg::MODE_ISWS2;
                        again   = 1'b1;
                    end
                    else fail_at(sc_phrase);
                end
                sts_pkg::MODE_ISW3:
                begin
                    if (is_wordc(c)) word_add(c);
                    else if (word_is("NULL"))
                    begin
                        emit_tok(sts_pkg::KIND_ISNOTNULL, sc_phrase, 11);
                        sc_mode = sts_pkg::MODE_IDLE;
                        again   = 1'b1;
                    end
                    else fail_at(sc_phrase);
                end
                sts_pkg::MODE_STR:
                begin
                    if (c == ChQuote)
                    begin
                        emit_tok(sts_pkg::KIND_STRING, sc_tok_start, sc_wlen);
                        sc_mode = sts_pkg::MODE_IDLE;
                    end
                    else if (sc_wlen < sts_pkg::MaxText) sc_wlen++;
                end
                sts_pkg::MODE_LT, sts_pkg::MODE_GT, sts_pkg::MODE_BANG:
                begin
                    pair   = (sc_mode == sts_pkg::MODE_LT) ? sts_pkg::KIND_LE :
                             (sc_mode == sts_pkg::MODE_GT) ? sts_pkg::KIND_GE : sts_pkg::KIND_NE;
                    single = (sc_mode == sts_pkg::MODE_LT) ? sts_pkg::KIND_LT :
                             (sc_mode == sts_pkg::MODE_GT) ? sts_pkg::KIND_GT :
                             sts_pkg::KIND_UNKNOWN;
                    sc_mode = sts_pkg::MODE_IDLE;
                    if (c == ChEq) emit_tok(pair, sc_tok_start, 2);
                    else
                    begin
                        emit_tok(single, sc_tok_start, 1);
                        again = 1'b1;
                    end
                end
                default:
                begin
                    sc_mode = sts_pkg::MODE_IDLE;
                    if (!is_space(c))
                    begin
                        sc_tok_start = p;
                        if (is_alnum(c) || c == ChUnder)
                        begin
                            word_begin(c);
                            sc_mode = sts_pkg::MODE_WORD;
                        end
                        else if (c == ChQuote)
                        begin
                            sc_tok_start = p + 1;
                            sc_wlen      = 0;
                            sc_mode      = sts_pkg::MODE_STR;
                        end
                        else if (c == ChLt) sc_mode = sts_pkg::MODE_LT;
                        else if (c == ChGt) sc_mode = sts_pkg::MODE_GT;
                        else if (c == ChBang) sc_mode = sts_pkg::MODE_BANG;
                        else emit_tok(symbol_kind(c), p, 1);
                    end
                end
            endcase
        end
    endfunction

    // Flush whatever token is open when the text ends.
    function automatic void flush_text();
        case (sc_mode)
            sts_pkg::MODE_WORD:
                if (word_is("IS")) fail_at(sc_tok_start);
                else emit_tok(sts_pkg::KIND_WORD, sc_tok_start, sc_wlen);
            sts_pkg::MODE_ISWS1, sts_pkg::MODE_ISWS2: fail_at(sc_phrase);
            sts_pkg::MODE_ISW2:
                if (word_is("NULL")) emit_tok(sts_pkg::KIND_ISNULL, sc_phrase, 7);
                else fail_at(sc_phrase);
            sts_pkg::MODE_ISW3:
                if (word_is("NULL")) emit_tok(sts_pkg::KIND_ISNOTNULL, sc_phrase, 11);
                else fail_at(sc_phrase);
            sts_pkg::MODE_STR:  fail_at(sc_tok_start - 1);
            sts_pkg::MODE_LT:   emit_tok(sts_pkg::KIND_LT, sc_tok_start, 1);
            sts_pkg::MODE_GT:   emit_tok(sts_pkg::KIND_GT, sc_tok_start, 1);
            sts_pkg::MODE_BANG: emit_tok(sts_pkg::KIND_UNKNOWN, sc_tok_start, 1);
            default: begin end
        endcase
        if (!sc_failed) emit_tok(sts_pkg::KIND_END, sc_pos, 0);
    endfunction

    function automatic void scan_char(logic [7:0] c, logic fin);
        bit ends;
        step_toks.delete();
        ends = (c == ChNul) || fin;
        if (!sc_failed && c != ChNul)
        begin
            if (sc_pos >= sts_pkg::MaxText) fail_at(sc_pos);
            else
            begin
                scan_byte(c, sc_pos);
                sc_pos++;
            end
        end
        if (ends)
        begin
            if (!sc_failed) flush_text();
            clear_scan();
        end
    endfunction

    // ---------------- random query text ----------------

    function automatic logic [7:0] word_char(bit first);
        int r;
        r = $urandom_range(0, first ? 62 : 63);
        if (r < 10) return 8'("0" + r);
        if (r < 36) return 8'("A" + r - 10);
        if (r < 62) return 8'("a" + r - 36);
        if (r == 62) return ChUnder;
        return ChDot;
    endfunction

    function automatic logic [7:0] str_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255)); while (b == ChQuote);
        return b;
    endfunction

    function automatic void push_str(string s);
        for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    endfunction

    function automatic void add_space();
        int n;
        int r;
        n = $urandom_range(1, 3);
        repeat (n)
        begin
            r = $urandom_range(0, 7);
            text_buf.push_back(r < 5 ? 8'(9 + r) : ChSpace);
        end
    endfunction

    function automatic void add_word();
        int n;
        n = $urandom_range(1, 6);
        text_buf.push_back(word_char(1'b1));
        repeat (n - 1) text_buf.push_back(word_char(1'b0));
    endfunction

    // Mostly well-formed IS NULL / IS NOT NULL, sometimes broken.
    function automatic void add_is_phrase();
        int v;
        push_str("IS");
        add_space();
        v = $urandom_range(0, 7);
        if (v < 3) push_str("NULL");
        else if (v < 6)
        begin
            push_str("NOT");
            add_space();
            push_str("NULL");
        end
        else if (v == 6)
        begin
            push_str("NOT");
            add_space();
            add_word();
        end
        else if ($urandom_range(0, 1) == 0) push_str("(");
        else add_word();
    endfunction

    function automatic void add_piece();
        int r;
        int n;
        r = $urandom_range(0, 19);
        if (r < 5) add_word();
        else if (r < 7)
        begin
            text_buf.push_back(ChQuote);
            n = $urandom_range(0, 5);
            repeat (n) text_buf.push_back(str_byte());
            if ($urandom_range(0, 7) != 0) text_buf.push_back(ChQuote);
        end
        else if (r < 11)
        begin
            text_buf.push_back(Syms[$urandom_range(0, 7)]);
            if ($urandom_range(0, 2) == 0) text_buf.push_back(ChEq);
        end
        else if (r < 14) add_is_phrase();
        else if (r == 14) text_buf.push_back(8'($urandom_range(1, 255)));
        else add_space();
    endfunction

    function automatic void build_text();
        int pieces;
        int style;
        text_buf.delete();
        pieces = $urandom_range(2, 7);
        for (int p = 0; p < pieces; p++)
        begin
            add_piece();
            if ($urandom_range(0, 3) != 0) add_space();
        end
        style = $urandom_range(0, 3);
        if (style <= 1)
        begin
            text_buf.push_back(ChNul);
            text_fin = style[0];
        end
        else text_fin = 1'b1;
    endfunction

    // ---------------- driving and checking ----------------

    task automatic flag_mismatch(string what, int got, int want);
        $display("mismatch: token %0d %s got %0d want %0d", tokens_seen, what, got, want);
        err_count++;
    endtask

    // Entered and left at a falling edge.
    task automatic send_char(logic [7:0] c, logic fin, logic typed, sts_pkg::token_t want);
        if (tx_idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        in_valid   = 1'b1;
        char_code  = c;
        final_char = fin;
        do @(posedge clk); while (!in_ready);
        scan_char(c, fin);
        if (typed) expected_tokens.push_back('{want, 1'b1});
        else
            for (int i = 0; i < step_toks.size(); i++)
                expected_tokens.push_back('{step_toks[i], i == step_toks.size() - 1});
        @(negedge clk);
    endtask

    task automatic drain_wait();
        in_valid = 1'b0;
        while (expected_tokens.size() != 0) @(negedge clk);
        repeat (DrainPad) @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (hold_seen != hold_asked)
        begin
            hold_seen = hold_asked;
            rx_stall  = LongHold;
        end
        else if (rx_stall == 0 && rx_idle_on && $urandom_range(0, 7) == 0)
            rx_stall = $urandom_range(1, 15);
        if (rx_stall > 0)
        begin
            out_ready = 1'b0;
            rx_stall--;
        end
        else out_ready = 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_tokens.size() == 0) flag_mismatch("unexpected, kind", kind, -1);
            else
            begin
                mon_want = expected_tokens.pop_front();
                if (kind !== mon_want.tok.kind)
                    flag_mismatch("kind", kind, mon_want.tok.kind);
                if (start_offset !== mon_want.tok.start)
                    flag_mismatch("start_offset", start_offset, mon_want.tok.start);
                if (token_length !== mon_want.tok.len)
                    flag_mismatch("token_length", token_length, mon_want.tok.len);
                if (run_last !== mon_want.last)
                    flag_mismatch("run_last", run_last, mon_want.last);
            end
            tokens_seen++;
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CycleLimit)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        sts_pkg::token_t t;
        int              i;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        char_code  = 8'h00;
        final_char = 1'b0;
        clear_scan();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (i = 0; i < DirRows; i++)
        begin
            t.kind  = dir_tab[i].k;
            t.start = dir_tab[i].st;
            t.len   = dir_tab[i].ln;
            send_char(dir_tab[i].ch, dir_tab[i].fin, dir_tab[i].typed, t);
        end
        drain_wait();

        // Long receiver stall while the sender keeps pushing: fills the bundle queue.
        tx_idle_on = 1'b0;
        hold_asked++;
        for (i = 0; i < HoldPairs; i++)
        begin
            send_char(ChBang, 1'b0, 1'b0, '0);
            send_char("(", 1'b0, 1'b0, '0);
        end
        send_char(ChNul, 1'b0, 1'b0, '0);
        drain_wait();
        tx_idle_on = 1'b1;

        while (rand_sent < RandItems)
        begin
            build_text();
            for (i = 0; i < text_buf.size(); i++)
            begin
                if (rand_sent >= RandItems - CalmTail)
                begin
                    tx_idle_on = 1'b0;
                    rx_idle_on = 1'b0;
                end
                send_char(text_buf[i], (i == text_buf.size() - 1) && text_fin, 1'b0, '0);
                rand_sent++;
            end
        end
        drain_wait();
        repeat (EndPad) @(negedge clk);

        if (expected_tokens.size() != 0) flag_mismatch("left over, count", 0,
                                                        expected_tokens.size());
        if (err_count == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule
